// ===== design/smbg_pkg.sv =====
// ----------------------------------------------------------------------------
// smbg_pkg
// Shared widths, register indexes and reset values of the box generator.
// ----------------------------------------------------------------------------
package smbg_pkg;

    localparam int SCORE_W    = 16;
    localparam int OFF_W      = 16;
    localparam int COORD_W    = 16;
    localparam int GRID_CFG_W = 10;
    localparam int INV_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int EXTRA_W    = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE       = 8'd3;

    localparam logic [GRID_CFG_W-1:0] RST_GRID_WIDTH  = 10'd512;
    localparam logic [GRID_CFG_W-1:0] RST_GRID_HEIGHT = 10'd512;
    localparam logic [SCORE_W-1:0]    RST_THRESHOLD   = 16'd39322;
    localparam logic [INV_W-1:0]      RST_INV_SCALE   = 24'd109227;

    // Corner offsets added to twice the cell position.
    localparam logic [EXTRA_W-1:0] NEAR_EDGE   = 4'd1;
    localparam logic [EXTRA_W-1:0] CELL_EXTENT = 4'd12;

    typedef struct packed {
        logic [SCORE_W-1:0]      face_score;
        logic signed [OFF_W-1:0] offset_left;
        logic signed [OFF_W-1:0] offset_top;
        logic signed [OFF_W-1:0] offset_right;
        logic signed [OFF_W-1:0] offset_bottom;
    } t_cell;

endpackage

// ===== design/smbg_ifs.sv =====
// ----------------------------------------------------------------------------
// smbg_ifs
// Valid/ready channels of the box generator: cells in, boxes out, config.
// ----------------------------------------------------------------------------
interface smbg_cell_if;
    logic                              valid;
    logic                              ready;
    logic [smbg_pkg::SCORE_W-1:0]      face_score;
    logic signed [smbg_pkg::OFF_W-1:0] offset_left;
    logic signed [smbg_pkg::OFF_W-1:0] offset_top;
    logic signed [smbg_pkg::OFF_W-1:0] offset_right;
    logic signed [smbg_pkg::OFF_W-1:0] offset_bottom;

    modport source (output valid, face_score, offset_left, offset_top,
                    offset_right, offset_bottom, input ready);
    modport sink   (input valid, face_score, offset_left, offset_top,
                    offset_right, offset_bottom, output ready);
endinterface

interface smbg_box_if;
    logic                              valid;
    logic                              ready;
    logic [smbg_pkg::COORD_W-1:0]      box_left;
    logic [smbg_pkg::COORD_W-1:0]      box_top;
    logic [smbg_pkg::COORD_W-1:0]      box_right;
    logic [smbg_pkg::COORD_W-1:0]      box_bottom;
    logic [smbg_pkg::SCORE_W-1:0]      box_score;
    logic signed [smbg_pkg::OFF_W-1:0] box_off_left;
    logic signed [smbg_pkg::OFF_W-1:0] box_off_top;
    logic signed [smbg_pkg::OFF_W-1:0] box_off_right;
    logic signed [smbg_pkg::OFF_W-1:0] box_off_bottom;

    modport source (output valid, box_left, box_top, box_right, box_bottom,
                    box_score, box_off_left, box_off_top, box_off_right,
                    box_off_bottom, input ready);
    modport sink   (input valid, box_left, box_top, box_right, box_bottom,
                    box_score, box_off_left, box_off_top, box_off_right,
                    box_off_bottom, output ready);
endinterface

interface smbg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [smbg_pkg::CFG_IDX_W-1:0]  index;
    logic [smbg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/smbg_corner.sv =====
// ----------------------------------------------------------------------------
// smbg_corner
// One box corner: floor((2*pos + extra) * inv_scale / 2^16), saturated.
// ----------------------------------------------------------------------------
module smbg_corner #(
    parameter int POS_W = 9
) (
    input  logic [POS_W-1:0]              i_pos,
    input  logic [smbg_pkg::EXTRA_W-1:0]  i_extra,
    input  logic [smbg_pkg::INV_W-1:0]    i_inv_scale,
    output logic [smbg_pkg::COORD_W-1:0]  o_coord
);

    localparam int NUM_W = POS_W + 4;
    localparam int TOP_W = smbg_pkg::FRAC_W + smbg_pkg::COORD_W;
    // Product is kept at least one bit wider than the unsaturated range.
    localparam int PW = (NUM_W + smbg_pkg::INV_W > TOP_W) ?
                        NUM_W + smbg_pkg::INV_W : TOP_W + 1;

    logic [NUM_W-1:0] num;
    logic [PW-1:0]    prod;

    assign num  = NUM_W'({i_pos, 1'b0}) + NUM_W'(i_extra);
    assign prod = PW'(num) * PW'(i_inv_scale);

    always_comb begin
        if (|prod[PW-1:TOP_W]) begin
            o_coord = '1;
        end else begin
            o_coord = prod[TOP_W-1:smbg_pkg::FRAC_W];
        end
    end

endmodule

// ===== design/score_map_box_generator.sv =====
// ----------------------------------------------------------------------------
// score_map_box_generator
// Raster-order score map cells in, candidate face boxes out.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Carries
//  i_cell    in   valid/ready        face score and four box offsets
//  o_box     out  valid/ready        four corners, score, offsets
//  i_cfg     in   valid/ready (rdy=1) register index and write data
//
//  One cell per cycle sustained while the output is not stalled. A cell is
//  held in the input stage, then the four corner multipliers feed the
//  result register; a request whose score does not exceed the threshold
//  leaves no result. A stalled output holds the result; the input stage
//  takes one more cell only if it is empty. Reset is synchronous, active
//  low, and clears counters and valid flags.
// ----------------------------------------------------------------------------
module score_map_box_generator #(
    parameter int MAX_GRID_DIM = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smbg_cell_if.sink   i_cell,
    smbg_box_if.source  o_box,
    smbg_cfg_if.sink    i_cfg
);

    localparam int DW = $clog2(MAX_GRID_DIM);
    localparam int EW = $clog2(MAX_GRID_DIM + 1);
    localparam int CW = (EW > smbg_pkg::GRID_CFG_W) ? EW : smbg_pkg::GRID_CFG_W;

    // Configuration registers.
    logic [smbg_pkg::GRID_CFG_W-1:0] r_grid_width;
    logic [smbg_pkg::GRID_CFG_W-1:0] r_grid_height;
    logic [smbg_pkg::SCORE_W-1:0]    r_threshold;
    logic [smbg_pkg::INV_W-1:0]      r_inv_scale;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= smbg_pkg::RST_GRID_WIDTH;
            r_grid_height <= smbg_pkg::RST_GRID_HEIGHT;
            r_threshold   <= smbg_pkg::RST_THRESHOLD;
            r_inv_scale   <= smbg_pkg::RST_INV_SCALE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                smbg_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg.data[smbg_pkg::GRID_CFG_W-1:0];
                end
                smbg_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg.data[smbg_pkg::GRID_CFG_W-1:0];
                end
                smbg_pkg::CFG_SCORE_THRESHOLD: begin
                    r_threshold <= i_cfg.data[smbg_pkg::SCORE_W-1:0];
                end
                smbg_pkg::CFG_INV_SCALE: begin
                    r_inv_scale <= i_cfg.data[smbg_pkg::INV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective grid size: zero acts as one, oversize clamps to the maximum.
    function automatic logic [CW-1:0] eff_dim(input logic [smbg_pkg::GRID_CFG_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext == '0) begin
            eff_dim = CW'(1);
        end else if (ext > CW'(MAX_GRID_DIM)) begin
            eff_dim = CW'(MAX_GRID_DIM);
        end else begin
            eff_dim = ext;
        end
    endfunction

    logic [CW-1:0] eff_w;
    logic [CW-1:0] eff_h;
    assign eff_w = eff_dim(r_grid_width);
    assign eff_h = eff_dim(r_grid_height);

    // Raster counters and input stage.
    logic [DW-1:0]       r_col, n_col;
    logic [DW-1:0]       r_row, n_row;
    logic                r_s1_valid;
    smbg_pkg::t_cell     r_s1_cell;
    logic [DW-1:0]       r_s1_col;
    logic [DW-1:0]       r_s1_row;
    logic                r_out_valid;
    logic                s2_free;
    logic                in_take;
    logic                s1_hit;

    assign s2_free    = !r_out_valid || o_box.ready;
    assign i_cell.ready = !r_s1_valid || s2_free;
    assign in_take    = i_cell.valid && i_cell.ready;
    assign s1_hit     = r_s1_cell.face_score > r_threshold;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (CW'(r_col) + CW'(1) >= eff_w) begin
            n_col = '0;
            if (CW'(r_row) + CW'(1) >= eff_h) begin
                n_row = '0;
            end else begin
                n_row = r_row + DW'(1);
            end
        end else begin
            n_col = r_col + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cell.ready) begin
                r_s1_valid <= i_cell.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cell.face_score    <= i_cell.face_score;
            r_s1_cell.offset_left   <= i_cell.offset_left;
            r_s1_cell.offset_top    <= i_cell.offset_top;
            r_s1_cell.offset_right  <= i_cell.offset_right;
            r_s1_cell.offset_bottom <= i_cell.offset_bottom;
            r_s1_col                <= r_col;
            r_s1_row                <= r_row;
        end
    end

    // Corner arithmetic.
    logic [smbg_pkg::COORD_W-1:0] left_c, top_c, right_c, bottom_c;

    smbg_corner #(.POS_W(DW)) u_left (
        .i_pos(r_s1_col), .i_extra(smbg_pkg::NEAR_EDGE),
        .i_inv_scale(r_inv_scale), .o_coord(left_c)
    );
    smbg_corner #(.POS_W(DW)) u_top (
        .i_pos(r_s1_row), .i_extra(smbg_pkg::NEAR_EDGE),
        .i_inv_scale(r_inv_scale), .o_coord(top_c)
    );
    smbg_corner #(.POS_W(DW)) u_right (
        .i_pos(r_s1_col), .i_extra(smbg_pkg::CELL_EXTENT),
        .i_inv_scale(r_inv_scale), .o_coord(right_c)
    );
    smbg_corner #(.POS_W(DW)) u_bottom (
        .i_pos(r_s1_row), .i_extra(smbg_pkg::CELL_EXTENT),
        .i_inv_scale(r_inv_scale), .o_coord(bottom_c)
    );

    // Result register.
    logic [smbg_pkg::COORD_W-1:0]      r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic [smbg_pkg::SCORE_W-1:0]      r_box_score;
    logic signed [smbg_pkg::OFF_W-1:0] r_off_left, r_off_top, r_off_right, r_off_bottom;
    logic                              out_load;

    assign out_load = r_s1_valid && s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid && s1_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_box_left   <= left_c;
            r_box_top    <= top_c;
            r_box_right  <= right_c;
            r_box_bottom <= bottom_c;
            r_box_score  <= r_s1_cell.face_score;
            r_off_left   <= r_s1_cell.offset_left;
            r_off_top    <= r_s1_cell.offset_top;
            r_off_right  <= r_s1_cell.offset_right;
            r_off_bottom <= r_s1_cell.offset_bottom;
        end
    end

    assign o_box.valid          = r_out_valid;
    assign o_box.box_left       = r_box_left;
    assign o_box.box_top        = r_box_top;
    assign o_box.box_right      = r_box_right;
    assign o_box.box_bottom     = r_box_bottom;
    assign o_box.box_score      = r_box_score;
    assign o_box.box_off_left   = r_off_left;
    assign o_box.box_off_top    = r_off_top;
    assign o_box.box_off_right  = r_off_right;
    assign o_box.box_off_bottom = r_off_bottom;

endmodule
